FILE: hdl/assert_macros.svh
// Assertion helpers used by the checker in masc_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define ASSERT_CLK_NR(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/masc_pkg.sv
`timescale 1ns / 1ps

package masc_pkg;

    // Field widths
    localparam int SAMPLE_W  = 12;
    localparam int SOURCE_W  = 2;
    localparam int RANGE_W   = 3;
    localparam int CHANNEL_W = 4;
    localparam int VALUE_W   = 33;
    localparam int KIND_W    = 2;
    localparam int OPER_W    = 13;   // sample plus range offset
    localparam int COEF_W    = 20;   // largest coefficient is 625 * 1000
    localparam int PROD_W    = 32;
    localparam int QUOT_W    = 20;

    // Scaling constants
    localparam logic [PROD_W-1:0]  FULL_CODE     = 32'd4095;
    localparam logic [COEF_W-1:0]  DIRECT_SCALE  = 20'd25600;
    localparam logic [COEF_W-1:0]  TEMP_STEP     = 20'd2500;
    localparam logic [VALUE_W-1:0] TEMP_OFFSET   = 33'd2780000;
    localparam logic [CHANNEL_W-1:0] CHANNELS    = 4'd10;

    typedef enum logic [SOURCE_W-1:0] {
        SRC_PRESCALED = 2'd0,
        SRC_DIRECT    = 2'd1,
        SRC_CURRENT   = 2'd2,
        SRC_TEMP      = 2'd3
    } t_source;

    typedef enum logic [KIND_W-1:0] {
        KIND_VOLTAGE = 2'd0,
        KIND_CURRENT = 2'd1,
        KIND_TEMP    = 2'd2,
        KIND_INVALID = 2'd3
    } t_kind;

    // How the product is finished in the last stage
    typedef enum logic [1:0] {
        PATH_DIV     = 2'd0,
        PATH_PASS    = 2'd1,
        PATH_TEMP    = 2'd2,
        PATH_INVALID = 2'd3
    } t_path;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  sample;
        t_source              source;
        logic [RANGE_W-1:0]   rng;
        logic [CHANNEL_W-1:0] channel;
    } t_item;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        t_path             path;
    } t_prod;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] quot;
        t_path             path;
    } t_est;

    // Error-compensation offset per prescaler range
    function automatic logic [OPER_W-1:0] range_offset(input logic [RANGE_W-1:0] rng);
        logic [OPER_W-1:0] v;
        unique case (rng)
            3'd0:    v = 13'd8;
            3'd1:    v = 13'd20;
            3'd2:    v = 13'd36;
            3'd3:    v = 13'd76;
            3'd4:    v = 13'd28;
            3'd5:    v = 13'd48;
            3'd6:    v = 13'd56;
            default: v = 13'd116;
        endcase
        return v;
    endfunction

    // Full-scale constant per prescaler range
    function automatic logic [COEF_W-1:0] range_full(input logic [RANGE_W-1:0] rng);
        logic [COEF_W-1:0] v;
        unique case (rng)
            3'd0:    v = 20'd163680;
            3'd1:    v = 20'd81840;
            3'd2:    v = 20'd40920;
            3'd3:    v = 20'd20460;
            3'd4:    v = 20'd10230;
            3'd5:    v = 20'd5115;
            3'd6:    v = 20'd2557;
            default: v = 20'd1278;
        endcase
        return v;
    endfunction

    // 625 times the conductance of each sense channel; zero off the table
    function automatic logic [COEF_W-1:0] current_coef(input logic [CHANNEL_W-1:0] ch);
        logic [COEF_W-1:0] v;
        unique case (ch)
            4'd0:    v = 20'd625;
            4'd1:    v = 20'd625;
            4'd2:    v = 20'd62500;
            4'd3:    v = 20'd133125;
            4'd4:    v = 20'd62500;
            4'd5:    v = 20'd625000;
            4'd6:    v = 20'd625;
            4'd7:    v = 20'd133125;
            4'd8:    v = 20'd284375;
            4'd9:    v = 20'd125000;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/masc_mul.sv
`timescale 1ns / 1ps

module masc_mul import masc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_prod o_data
);

    logic              r_valid;
    t_prod             r_data;
    logic [OPER_W-1:0] w_oper;
    logic [COEF_W-1:0] w_coef;
    t_path             w_path;
    logic [PROD_W-1:0] w_full;

    // Operand and coefficient choice per source
    always_comb begin
        w_oper = {1'b0, i_item.sample};
        w_coef = '0;
        w_path = PATH_DIV;
        unique case (i_item.source)
            SRC_PRESCALED: begin
                w_oper = {1'b0, i_item.sample} + range_offset(i_item.rng);
                w_coef = range_full(i_item.rng);
                w_path = PATH_DIV;
            end
            SRC_DIRECT: begin
                w_coef = DIRECT_SCALE;
                w_path = PATH_DIV;
            end
            SRC_CURRENT: begin
                w_coef = current_coef(i_item.channel);
                w_path = (i_item.channel < CHANNELS) ? PATH_PASS : PATH_INVALID;
            end
            SRC_TEMP: begin
                w_coef = TEMP_STEP;
                w_path = PATH_TEMP;
            end
        endcase
    end

    // Single 13x20 multiply; the product never exceeds 32 bits
    assign w_full  = {{(PROD_W-OPER_W){1'b0}}, w_oper} * {{(PROD_W-COEF_W){1'b0}}, w_coef};
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data.prod <= w_full;
            r_data.path <= w_path;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: hdl/masc_div.sv
`timescale 1ns / 1ps

module masc_div import masc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_prod i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_est  o_data
);

    localparam int SUM_W = PROD_W + 12;

    logic             r_valid;
    t_est             r_data;
    logic [SUM_W-1:0] w_sum;

    // 4095 * 4097 = 2^24 - 1, so n * 4097 >> 24 is n / 4095 or one short
    assign w_sum   = {12'b0, i_data.prod} + {i_data.prod, 12'b0};
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data.prod <= i_data.prod;
            r_data.quot <= w_sum[SUM_W-1:24];
            r_data.path <= i_data.path;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: hdl/masc_out.sv
`timescale 1ns / 1ps

module masc_out import masc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_est               i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [VALUE_W-1:0] o_value,
    output t_kind              o_kind
);

    logic               r_valid;
    logic [VALUE_W-1:0] r_value;
    t_kind              r_kind;
    logic [PROD_W-1:0]  w_qmul;
    logic [PROD_W-1:0]  w_rem;
    logic [QUOT_W-1:0]  w_quot;
    logic [VALUE_W-1:0] w_value;
    t_kind              w_kind;

    // Remainder check: quotient estimate is exact or one short
    assign w_qmul = {i_data.quot, 12'b0} - {12'b0, i_data.quot};
    assign w_rem  = i_data.prod - w_qmul;
    assign w_quot = i_data.quot + QUOT_W'(w_rem >= FULL_CODE);

    // Final value and kind
    always_comb begin
        unique case (i_data.path)
            PATH_DIV: begin
                w_value = {{(VALUE_W-QUOT_W){1'b0}}, w_quot};
                w_kind  = KIND_VOLTAGE;
            end
            PATH_PASS: begin
                w_value = {1'b0, i_data.prod};
                w_kind  = KIND_CURRENT;
            end
            PATH_TEMP: begin
                w_value = {1'b0, i_data.prod} - TEMP_OFFSET;
                w_kind  = KIND_TEMP;
            end
            default: begin
                w_value = '1;
                w_kind  = KIND_INVALID;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_value <= w_value;
            r_kind  <= w_kind;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_kind  = r_kind;

endmodule

FILE: hdl/monitor_adc_sample_scaler.sv
// Channel   Dir  tdata                                  tuser
// s_axis    in   sample, range_sel, sense_channel (24b)  source_sel (2b)
// m_axis    out  scaled_value, signed (33b of 40b)      kind (2b)
//
// One word per cycle sustained while m_axis_tready stays high; a word passes
// through four registers (input, multiply, quotient estimate, result) in
// that order before its result shows on m_axis.
// Every stage has its own valid bit and passes on when the next is free, so
// a waiting result does not stop input while earlier stages have room.
// i_rst_n is synchronous, active low, and clears the valid bits only.
`timescale 1ns / 1ps

module monitor_adc_sample_scaler import masc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // sample[11:0], range_sel[14:12], sense_channel[18:15]
    input  logic [1:0]  s_axis_tuser,   // source_sel[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // scaled_value[32:0]
    output logic [1:0]  m_axis_tuser    // kind[1:0]
);

    logic               r_in_valid;
    t_item              r_in_item;
    logic               w_mul_ready;
    logic               w_mul_valid;
    t_prod              w_mul_data;
    logic               w_div_ready;
    logic               w_div_valid;
    t_est               w_div_data;
    logic               w_out_ready;
    logic [VALUE_W-1:0] w_value;
    t_kind              w_kind;

    // Input register
    assign s_axis_tready = !r_in_valid || w_mul_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item.sample  <= s_axis_tdata[11:0];
            r_in_item.rng     <= s_axis_tdata[14:12];
            r_in_item.channel <= s_axis_tdata[18:15];
            r_in_item.source  <= t_source'(s_axis_tuser);
        end
    end

    masc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (w_mul_ready),
        .i_item  (r_in_item),
        .o_valid (w_mul_valid),
        .i_ready (w_div_ready),
        .o_data  (w_mul_data)
    );

    masc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mul_valid),
        .o_ready (w_div_ready),
        .i_data  (w_mul_data),
        .o_valid (w_div_valid),
        .i_ready (w_out_ready),
        .o_data  (w_div_data)
    );

    masc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid),
        .o_ready (w_out_ready),
        .i_data  (w_div_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_value (w_value),
        .o_kind  (w_kind)
    );

    assign m_axis_tdata = {7'b0, w_value};
    assign m_axis_tuser = w_kind;

endmodule

FILE: hdl/masc_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module masc_chk import masc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // Nothing comes out the cycle after a reset edge
    `ASSERT_CLK_NR(a_rst_empty, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // A stalled result holds
    `ASSERT_CLK(a_out_hold,
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "stalled result changed")

    // Invalid channel gives all ones
    `ASSERT_CLK(a_invalid_ones,
        m_axis_tvalid && m_axis_tuser == KIND_INVALID |->
            m_axis_tdata[32:0] == {33{1'b1}},
        "invalid kind without all-ones value")

    // Voltages and currents are never negative, padding stays zero
    `ASSERT_CLK(a_sign_pad,
        m_axis_tvalid && (m_axis_tuser == KIND_VOLTAGE || m_axis_tuser == KIND_CURRENT) |->
            !m_axis_tdata[32] && m_axis_tdata[39:33] == 7'b0,
        "negative voltage or current")

endmodule

bind monitor_adc_sample_scaler masc_chk u_masc_chk (.*);

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import masc_pkg::*;

    localparam int IDLE_LIMIT   = 4000;   // cycles with no word moving on either side
    localparam int SETTLE_LOOPS = 12;     // pipeline is four deep; leave some slack
    localparam int PHASE_WORDS  = 100;

    // One converter sample as it goes onto the slave side
    typedef struct packed {
        logic [11:0] sample;
        t_source     source;
        logic [2:0]  rng;
        logic [3:0]  channel;
    } adc_word_t;

    // One scaled reading as it should leave the master side
    typedef struct packed {
        logic signed [32:0] value;
        t_kind              kind;
    } scaled_reading_t;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // sample[11:0], range_sel[14:12], sense_channel[18:15]
    logic [1:0]  s_axis_tuser  = '0;   // source_sel[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // scaled_value[32:0]
    logic [1:0]  m_axis_tuser;         // kind[1:0]

    adc_word_t       adc_words[$];     // samples waiting to be sent
    scaled_reading_t due_readings[$];  // readings owed by the block, oldest first
    adc_word_t       on_bus;
    int              send_idle_pct  = 0;
    int              sink_stall_pct = 0;
    int              mismatch_count = 0;
    int              quiet_cycles   = 0;
    logic            stim_done      = 1'b0;
    logic            stuck          = 1'b0;

    monitor_adc_sample_scaler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Per-range error compensation and full-scale factor of the prescaler
    function automatic void prescaler_range(input logic [2:0] rng,
                                            output longint offset, output longint full);
        case (rng)
            3'd0: begin offset = 8;   full = 163680; end
            3'd1: begin offset = 20;  full = 81840;  end
            3'd2: begin offset = 36;  full = 40920;  end
            3'd3: begin offset = 76;  full = 20460;  end
            3'd4: begin offset = 28;  full = 10230;  end
            3'd5: begin offset = 48;  full = 5115;   end
            3'd6: begin offset = 56;  full = 2557;   end
            default: begin offset = 116; full = 1278; end
        endcase
    endfunction

    // Conductance of each sense resistor on the table
    function automatic longint sense_conductance(input logic [3:0] ch);
        case (ch)
            4'd2, 4'd4: return 100;
            4'd3, 4'd7: return 213;
            4'd5:       return 1000;
            4'd8:       return 455;
            4'd9:       return 200;
            default:    return 1;
        endcase
    endfunction

    // Scaled reading in units of 1/10000 for one sample
    function automatic scaled_reading_t scale_reading(input adc_word_t w);
        scaled_reading_t r;
        longint          x;
        longint          v;
        longint          offset;
        longint          full;
        x = longint'(w.sample);
        r.kind = KIND_VOLTAGE;
        case (w.source)
            SRC_PRESCALED: begin
                prescaler_range(w.rng, offset, full);
                v = ((x + offset) * full) / 4095;
            end
            SRC_DIRECT: begin
                v = (x * 25600) / 4095;
            end
            SRC_CURRENT: begin
                if (w.channel < CHANNELS) begin
                    v = x * 625 * sense_conductance(w.channel);
                    r.kind = KIND_CURRENT;
                end else begin
                    v = -1;
                    r.kind = KIND_INVALID;
                end
            end
            default: begin
                v = x * 2500 - 2780000;
                r.kind = KIND_TEMP;
            end
        endcase
        r.value = v[32:0];
        return r;
    endfunction

    function automatic adc_word_t random_word();
        adc_word_t w;
        case ($urandom_range(9))
            0:       w.sample = 12'd0;
            1:       w.sample = 12'hFFF;
            default: w.sample = 12'($urandom_range(4095));
        endcase
        w.source = t_source'($urandom_range(3));
        w.rng    = 3'($urandom_range(7));
        // keep most current readings on the table, some off it
        if ($urandom_range(3) == 0)
            w.channel = 4'($urandom_range(15));
        else
            w.channel = 4'($urandom_range(9));
        return w;
    endfunction

    task automatic queue_word(input logic [11:0] sample, input t_source src,
                              input logic [2:0] rng, input logic [3:0] ch);
        adc_word_t w;
        w.sample  = sample;
        w.source  = src;
        w.rng     = rng;
        w.channel = ch;
        adc_words.push_back(w);
    endtask

    // Slave-side driver: predict on acceptance, then offer the next word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                due_readings.push_back(scale_reading(on_bus));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (adc_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = adc_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'd0, on_bus.channel, on_bus.rng, on_bus.sample};
                    s_axis_tuser  <= on_bus.source;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Master-side monitor: compare each word with the oldest owed reading
    always @(posedge i_clk) begin
        scaled_reading_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_readings.size() == 0) begin
                    $error("result word with no reading owed: value %0d kind %0d",
                           $signed(m_axis_tdata[32:0]), m_axis_tuser);
                    mismatch_count++;
                end else begin
                    want = due_readings.pop_front();
                    if (m_axis_tdata[32:0] !== want.value) begin
                        $error("scaled_value: expected %0d, got %0d",
                               want.value, $signed(m_axis_tdata[32:0]));
                        mismatch_count++;
                    end
                    if (m_axis_tuser !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                        mismatch_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
            stuck <= 1'b1;
    end

    // Stimulus: reset, then four phases with differing sender idle and sink stall rates, draining fully between them
    initial begin : stimulus
        int p;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (p = 0; p < 4; p++) begin
            @(negedge i_clk);
            case (p)
                0:       begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin send_idle_pct = 64; sink_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  sink_stall_pct = 64; end
                default: begin send_idle_pct = 34; sink_stall_pct = 34; end
            endcase
            if (p == 0) begin
                // prescaler: every range, sample at both ends, range offset at top
                for (int r = 0; r < 8; r++)
                    queue_word((r % 2 == 0) ? 12'hFFF : 12'd0, SRC_PRESCALED, 3'(r), 4'hF);
                queue_word(12'd0,   SRC_DIRECT, 3'd7, 4'd0);
                queue_word(12'hFFF, SRC_DIRECT, 3'd0, 4'hF);
                // current: largest coefficient, zero sample, both ends of the table
                queue_word(12'hFFF, SRC_CURRENT, 3'd0, 4'd5);
                queue_word(12'd0,   SRC_CURRENT, 3'd7, 4'd0);
                queue_word(12'hFFF, SRC_CURRENT, 3'd0, 4'd9);
                queue_word(12'hFFF, SRC_CURRENT, 3'd7, 4'd8);
                // current: channels off the table read as invalid
                queue_word(12'd1234, SRC_CURRENT, 3'd0, 4'd10);
                queue_word(12'hFFF,  SRC_CURRENT, 3'd7, 4'hF);
                // temperature: most negative, just below zero, exactly zero, top
                queue_word(12'd0,    SRC_TEMP, 3'd7, 4'hF);
                queue_word(12'd1111, SRC_TEMP, 3'd0, 4'd0);
                queue_word(12'd1112, SRC_TEMP, 3'd5, 4'd12);
                queue_word(12'hFFF,  SRC_TEMP, 3'd0, 4'd0);
            end
            repeat (PHASE_WORDS) adc_words.push_back(random_word());
            // sender holds off until the block has handed back everything
            while (adc_words.size() != 0 || s_axis_tvalid || due_readings.size() != 0)
                @(negedge i_clk);
        end
        repeat (SETTLE_LOOPS) @(negedge i_clk);
        stim_done = 1'b1;
    end

    // End of run
    initial begin : run_end
        wait (stim_done || stuck);
        if (!stuck && mismatch_count == 0 && due_readings.size() == 0)
            $display("monitor_adc_sample_scaler test passed");
        else
            $display("monitor_adc_sample_scaler test failed");
        $finish;
    end

endmodule
